### hw/rtl/ffrs_pkg.sv
package ffrs_pkg;

  localparam int unsigned CHUNK_SECTORS = 524288;

  localparam int SEC_W   = 32;
  localparam int CNT_W   = 20;
  localparam int SUM_W   = CNT_W + 1;
  localparam int CLUS_W  = 28;
  localparam int SPC_W   = 8;
  localparam int BYTES_W = 42;
  localparam int LONG_W  = 44;
  localparam int ADDR_W  = 4;
  localparam int SECTOR_SHIFT = 9;

  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  localparam logic [CLUS_W-1:0] START_CLUSTER = CLUS_W'(2);
  localparam logic [SPC_W-1:0]  SPC_RESET     = SPC_W'(64);
  localparam logic [SUM_W-1:0]  CHUNK_LIM     = SUM_W'(CHUNK_SECTORS);

  localparam logic [ADDR_W-1:0] REG_DATA_START = ADDR_W'(0);
  localparam logic [ADDR_W-1:0] REG_SPC        = ADDR_W'(1);

  typedef struct packed {
    logic [SEC_W-1:0] data_start;
    logic [SPC_W-1:0] spc;
  } cfg_t;

  typedef struct packed {
    logic             is_free;
    logic             last;
    logic [SEC_W-1:0] clus_sector;
  } item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

  typedef struct packed {
    logic               erase_valid;
    logic [SEC_W-1:0]   start;
    logic [CNT_W-1:0]   count;
    logic [BYTES_W-1:0] bytes;
    logic [CLUS_W-1:0]  best;
    logic               scan_done;
  } res_t;

endpackage

### hw/rtl/ffrs_if.sv
interface ffrs_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] fat_entry;
  logic        last_entry;

  modport source(output valid, output fat_entry, output last_entry, input ready);
  modport sink(input valid, input fat_entry, input last_entry, output ready);
endinterface

interface ffrs_out_if;
  logic        valid;
  logic        ready;
  logic        erase_valid;
  logic [31:0] erase_start_sector;
  logic [19:0] erase_sector_count;
  logic [41:0] total_bytes_erased;
  logic [43:0] longest_free_run_bytes;
  logic        scan_done;

  modport source(output valid, output erase_valid, output erase_start_sector,
                 output erase_sector_count, output total_bytes_erased,
                 output longest_free_run_bytes, output scan_done, input ready);
  modport sink(input valid, input erase_valid, input erase_start_sector,
               input erase_sector_count, input total_bytes_erased,
               input longest_free_run_bytes, input scan_done, output ready);
endinterface

interface ffrs_cfg_if;
  logic        valid;
  logic        ready;
  logic [3:0]  addr;
  logic [31:0] data;

  modport source(output valid, output addr, output data, input ready);
  modport sink(input valid, input addr, input data, output ready);
endinterface

### hw/rtl/ffrs_front.sv
module ffrs_front (
  input  logic            clk,
  input  logic            rst_n,
  ffrs_in_if.sink         in_if,
  input  ffrs_pkg::cfg_t  cfg,
  input  ffrs_pkg::qstat_t q_stat,
  output logic            push,
  output ffrs_pkg::item_t push_item
);

  logic [ffrs_pkg::CLUS_W-1:0] cc_r;
  logic [ffrs_pkg::CLUS_W-1:0] cc_nxt;
  logic [ffrs_pkg::SEC_W-1:0]  offset;
  logic [ffrs_pkg::SEC_W+ffrs_pkg::SPC_W-1:0] prod;

  assign in_if.ready = !q_stat.full;
  assign push        = in_if.valid && in_if.ready;

  // cluster n starts at data start + (n - 2) * spc, modulo 2^32
  always_comb begin
    offset = ffrs_pkg::SEC_W'(cc_r) - ffrs_pkg::SEC_W'(ffrs_pkg::START_CLUSTER);
    prod   = offset * cfg.spc;
    push_item.is_free     = (in_if.fat_entry[ffrs_pkg::CLUS_W-1:0] == '0);
    push_item.last        = in_if.last_entry;
    push_item.clus_sector = cfg.data_start + prod[ffrs_pkg::SEC_W-1:0];
    cc_nxt = in_if.last_entry ? ffrs_pkg::START_CLUSTER : cc_r + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cc_r <= ffrs_pkg::START_CLUSTER;
    end else if (push) begin
      cc_r <= cc_nxt;
    end
  end

endmodule

### hw/rtl/ffrs_queue.sv
module ffrs_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  ffrs_pkg::item_t  push_item,
  input  logic             pop,
  output ffrs_pkg::item_t  pop_item,
  output ffrs_pkg::qstat_t q_stat
);

  ffrs_pkg::item_t              mem_r [ffrs_pkg::Q_DEPTH];
  logic [ffrs_pkg::Q_PTR_W-1:0] wr_r;
  logic [ffrs_pkg::Q_PTR_W-1:0] rd_r;
  logic [ffrs_pkg::Q_PTR_W-1:0] wr_nxt;
  logic [ffrs_pkg::Q_PTR_W-1:0] rd_nxt;
  logic [ffrs_pkg::Q_CNT_W-1:0] cnt_r;
  logic [ffrs_pkg::Q_CNT_W-1:0] cnt_nxt;

  localparam logic [ffrs_pkg::Q_PTR_W-1:0] LAST_PTR = ffrs_pkg::Q_PTR_W'(ffrs_pkg::Q_DEPTH - 1);

  always_comb begin
    wr_nxt  = wr_r;
    rd_nxt  = rd_r;
    if (push) begin
      wr_nxt = (wr_r == LAST_PTR) ? '0 : wr_r + 1'b1;
    end
    if (pop) begin
      rd_nxt = (rd_r == LAST_PTR) ? '0 : rd_r + 1'b1;
    end
    cnt_nxt = cnt_r + ffrs_pkg::Q_CNT_W'(push) - ffrs_pkg::Q_CNT_W'(pop);
  end

  assign pop_item     = mem_r[rd_r];
  assign q_stat.full  = (cnt_r == ffrs_pkg::Q_CNT_W'(ffrs_pkg::Q_DEPTH));
  assign q_stat.empty = (cnt_r == '0);

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

### hw/rtl/ffrs_back.sv
module ffrs_back (
  input  logic             clk,
  input  logic             rst_n,
  input  ffrs_pkg::cfg_t   cfg,
  input  ffrs_pkg::qstat_t q_stat,
  input  ffrs_pkg::item_t  item,
  output logic             pop,
  ffrs_out_if.source       out_if
);

  logic [ffrs_pkg::SEC_W-1:0]   chunk_start_r, start_nxt;
  logic [ffrs_pkg::CNT_W-1:0]   chunk_sec_r, sec_nxt;
  logic [ffrs_pkg::CLUS_W-1:0]  run_r, run_nxt;
  logic [ffrs_pkg::CLUS_W-1:0]  best_r, best_nxt;
  logic [ffrs_pkg::BYTES_W-1:0] bytes_r, bytes_nxt;

  logic [ffrs_pkg::SEC_W-1:0]   base;
  logic [ffrs_pkg::SUM_W-1:0]   sum;
  logic                         issue;
  logic [ffrs_pkg::SEC_W-1:0]   cmd_start;
  logic [ffrs_pkg::SUM_W-1:0]   cmd_count;

  ffrs_pkg::res_t res_r, res_nxt;
  logic           res_valid_r;
  logic           res_ld, out_ld;

  logic                              out_valid_r;
  ffrs_pkg::res_t                    out_r;
  logic [ffrs_pkg::LONG_W-1:0]       longest_r, longest_nxt;
  logic [ffrs_pkg::CLUS_W+ffrs_pkg::SPC_W-1:0] best_prod;

  assign out_ld = !out_valid_r || out_if.ready;
  assign res_ld = !res_valid_r || out_ld;
  assign pop    = !q_stat.empty && res_ld;

  always_comb begin
    base      = (chunk_sec_r == '0) ? item.clus_sector : chunk_start_r;
    sum       = {1'b0, chunk_sec_r} + ffrs_pkg::SUM_W'(cfg.spc);
    issue     = 1'b0;
    cmd_start = '0;
    cmd_count = '0;
    start_nxt = chunk_start_r;
    sec_nxt   = chunk_sec_r;
    run_nxt   = run_r;
    best_nxt  = best_r;
    if (item.is_free) begin
      start_nxt = base;
      if (sum >= ffrs_pkg::CHUNK_LIM) begin
        issue     = 1'b1;
        cmd_start = base;
        cmd_count = ffrs_pkg::CHUNK_LIM;
        start_nxt = base + ffrs_pkg::SEC_W'(ffrs_pkg::CHUNK_SECTORS);
        sec_nxt   = ffrs_pkg::CNT_W'(sum - ffrs_pkg::CHUNK_LIM);
      end else begin
        sec_nxt = sum[ffrs_pkg::CNT_W-1:0];
      end
      if (run_r != '1) begin
        run_nxt = run_r + 1'b1;
      end
      if (run_nxt > best_r) begin
        best_nxt = run_nxt;
      end
    end else begin
      if (chunk_sec_r != '0) begin
        issue     = 1'b1;
        cmd_start = chunk_start_r;
        cmd_count = {1'b0, chunk_sec_r};
      end
      sec_nxt = '0;
      run_nxt = '0;
    end
    // flush a pending partial chunk at end of table; a leftover past a chunk issued on the last entry is dropped
    if (item.last) begin
      if (!issue && sec_nxt != '0) begin
        issue     = 1'b1;
        cmd_start = start_nxt;
        cmd_count = {1'b0, sec_nxt};
      end
      sec_nxt = '0;
    end
    bytes_nxt = issue ?
      bytes_r + ffrs_pkg::BYTES_W'({cmd_count, {ffrs_pkg::SECTOR_SHIFT{1'b0}}}) : bytes_r;

    res_nxt.erase_valid = issue;
    res_nxt.start       = cmd_start;
    res_nxt.count       = cmd_count[ffrs_pkg::CNT_W-1:0];
    res_nxt.bytes       = bytes_nxt;
    res_nxt.best        = best_nxt;
    res_nxt.scan_done   = item.last;

    best_prod   = res_r.best * cfg.spc;
    longest_nxt = ffrs_pkg::LONG_W'({best_prod, {ffrs_pkg::SECTOR_SHIFT{1'b0}}});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chunk_start_r <= '0;
      chunk_sec_r   <= '0;
      run_r         <= '0;
      best_r        <= '0;
      bytes_r       <= '0;
    end else if (pop) begin
      if (item.last) begin
        chunk_start_r <= '0;
        chunk_sec_r   <= '0;
        run_r         <= '0;
        best_r        <= '0;
        bytes_r       <= '0;
      end else begin
        chunk_start_r <= start_nxt;
        chunk_sec_r   <= sec_nxt;
        run_r         <= run_nxt;
        best_r        <= best_nxt;
        bytes_r       <= bytes_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (res_ld) begin
        res_valid_r <= pop;
      end
      if (out_ld) begin
        out_valid_r <= res_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      res_r <= res_nxt;
    end
    if (out_ld && res_valid_r) begin
      out_r     <= res_r;
      longest_r <= longest_nxt;
    end
  end

  assign out_if.valid                  = out_valid_r;
  assign out_if.erase_valid            = out_r.erase_valid;
  assign out_if.erase_start_sector     = out_r.start;
  assign out_if.erase_sector_count     = out_r.count;
  assign out_if.total_bytes_erased     = out_r.bytes;
  assign out_if.longest_free_run_bytes = longest_r;
  assign out_if.scan_done              = out_r.scan_done;

endmodule

### hw/rtl/fat_free_run_erase_scanner.sv
// each input transaction passes the queue, the run update and the byte scaling registers in order to its result
// throughput: 1 transaction per cycle while the result side is ready, set by the run and chunk update
// a 2-entry queue parts the classifying front from the run-tracking back
// reset (rst_n low, synchronous): scan state cleared, cluster count at 2,
// data area start 0, sectors per cluster 64, queue and output stages empty
module fat_free_run_erase_scanner (
  input  logic        clk,
  input  logic        rst_n,
  ffrs_in_if.sink     in_if,
  ffrs_out_if.source  out_if,
  ffrs_cfg_if.sink    cfg_if
);

  ffrs_pkg::cfg_t   cfg;
  ffrs_pkg::qstat_t q_stat;
  ffrs_pkg::item_t  push_item;
  ffrs_pkg::item_t  pop_item;
  logic             push;
  logic             pop;

  logic [ffrs_pkg::SEC_W-1:0] data_start_r;
  logic [ffrs_pkg::SPC_W-1:0] spc_r;

  assign cfg_if.ready   = 1'b1;
  assign cfg.data_start = data_start_r;
  assign cfg.spc        = spc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      data_start_r <= '0;
      spc_r        <= ffrs_pkg::SPC_RESET;
    end else if (cfg_if.valid && cfg_if.ready) begin
      unique case (cfg_if.addr)
        ffrs_pkg::REG_DATA_START: data_start_r <= cfg_if.data;
        ffrs_pkg::REG_SPC:        spc_r        <= cfg_if.data[ffrs_pkg::SPC_W-1:0];
        default: begin
        end
      endcase
    end
  end

  ffrs_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_if     (in_if),
    .cfg       (cfg),
    .q_stat    (q_stat),
    .push      (push),
    .push_item (push_item)
  );

  ffrs_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .pop_item  (pop_item),
    .q_stat    (q_stat)
  );

  ffrs_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg    (cfg),
    .q_stat (q_stat),
    .item   (pop_item),
    .pop    (pop),
    .out_if (out_if)
  );

  a_no_cmd_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_if.valid && !out_if.erase_valid |->
      out_if.erase_start_sector == '0 && out_if.erase_sector_count == '0)
    else $error("result without erase command carries a range");

  a_queue_state: assert property (@(posedge clk) disable iff (!rst_n)
    !(q_stat.full && q_stat.empty))
    else $error("queue reports full and empty");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_if.valid)
    else $error("result valid right after reset");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !q_stat.empty)
    else $error("pop from empty queue");

endmodule

### bench/erase_scan_checker.sv
`timescale 1ns / 1ps

module erase_scan_checker (
  input  logic clk,
  input  logic rst_n,
  ffrs_in_if   in_ch,
  ffrs_out_if  out_ch,
  ffrs_cfg_if  cfg_ch,
  output int   fail_count,
  output int   pending_results,
  output int   commands_seen,
  output int   scans_seen
);

  typedef struct packed {
    logic        erase_valid;
    logic [31:0] start_sector;
    logic [19:0] sector_count;
    logic [41:0] bytes_erased;
    logic [43:0] longest_run;
    logic        done;
  } erase_result_t;

  logic [31:0] data_start_q;
  logic [7:0]  spc_q;

  logic [27:0] cluster_no;
  logic [31:0] pend_start;
  logic [20:0] pend_secs;
  logic [27:0] run_len;
  logic [27:0] best_len;
  logic [41:0] erased_bytes;

  erase_result_t expected_q[$];
  erase_result_t want;
  erase_result_t got;
  int results_seen;

  function automatic void clear_scan();
    cluster_no   = ffrs_pkg::START_CLUSTER;
    pend_start   = '0;
    pend_secs    = '0;
    run_len      = '0;
    best_len     = '0;
    erased_bytes = '0;
  endfunction

  function automatic erase_result_t scan_entry(input logic [31:0] raw, input logic last);
    erase_result_t r;
    logic [20:0]   sum;
    logic          issue;
    logic [31:0]   cmd_start;
    logic [20:0]   cmd_count;
    logic [63:0]   longest;
    issue     = 1'b0;
    cmd_start = '0;
    cmd_count = '0;
    if (raw[27:0] == 28'd0) begin
      if (pend_secs == 21'd0) begin
        pend_start = data_start_q + (32'(cluster_no) - 32'd2) * 32'(spc_q);
      end
      sum = pend_secs + 21'(spc_q);
      if (sum >= 21'(ffrs_pkg::CHUNK_SECTORS)) begin
        issue      = 1'b1;
        cmd_start  = pend_start;
        cmd_count  = 21'(ffrs_pkg::CHUNK_SECTORS);
        pend_start = pend_start + 32'(ffrs_pkg::CHUNK_SECTORS);
        pend_secs  = sum - 21'(ffrs_pkg::CHUNK_SECTORS);
      end else begin
        pend_secs = sum;
      end
      if (run_len != '1) begin
        run_len = run_len + 28'd1;
      end
      if (run_len > best_len) begin
        best_len = run_len;
      end
    end else begin
      if (pend_secs != 21'd0) begin
        issue     = 1'b1;
        cmd_start = pend_start;
        cmd_count = pend_secs;
        pend_secs = '0;
      end
      run_len = '0;
    end

    // leftover past a full chunk on the final entry is dropped
    if (last) begin
      if (!issue && pend_secs != 21'd0) begin
        issue     = 1'b1;
        cmd_start = pend_start;
        cmd_count = pend_secs;
      end
      pend_secs = '0;
    end

    if (issue) begin
      erased_bytes = erased_bytes + (42'(cmd_count) << 9);
    end
    longest = 64'(best_len) * 64'(spc_q) * 64'd512;

    r.erase_valid  = issue;
    r.start_sector = issue ? cmd_start : 32'd0;
    r.sector_count = issue ? cmd_count[19:0] : 20'd0;
    r.bytes_erased = erased_bytes;
    r.longest_run  = longest[43:0];
    r.done         = last;

    if (last) begin
      clear_scan();
    end else begin
      cluster_no = cluster_no + 28'd1;
    end
    return r;
  endfunction

  task automatic flag(input string what, input logic [63:0] want_v, input logic [63:0] got_v);
    fail_count++;
    if (fail_count <= 10) begin
      $display("result %0d: %s expected %0h got %0h", results_seen, what, want_v, got_v);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      data_start_q = '0;
      spc_q        = ffrs_pkg::SPC_RESET;
      clear_scan();
      expected_q.delete();
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.addr)
          ffrs_pkg::REG_DATA_START: data_start_q = cfg_ch.data;
          ffrs_pkg::REG_SPC:        spc_q = cfg_ch.data[7:0];
          default: ;
        endcase
      end

      // retire before pushing: a result never leaves in its own input cycle
      if (out_ch.valid && out_ch.ready) begin
        got.erase_valid  = out_ch.erase_valid;
        got.start_sector = out_ch.erase_start_sector;
        got.sector_count = out_ch.erase_sector_count;
        got.bytes_erased = out_ch.total_bytes_erased;
        got.longest_run  = out_ch.longest_free_run_bytes;
        got.done         = out_ch.scan_done;
        if (expected_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) begin
            $display("result %0d arrived with nothing expected", results_seen);
          end
        end else begin
          want = expected_q.pop_front();
          if (got.erase_valid !== want.erase_valid)
            flag("erase_valid", 64'(want.erase_valid), 64'(got.erase_valid));
          if (got.start_sector !== want.start_sector)
            flag("erase_start_sector", 64'(want.start_sector), 64'(got.start_sector));
          if (got.sector_count !== want.sector_count)
            flag("erase_sector_count", 64'(want.sector_count), 64'(got.sector_count));
          if (got.bytes_erased !== want.bytes_erased)
            flag("total_bytes_erased", 64'(want.bytes_erased), 64'(got.bytes_erased));
          if (got.longest_run !== want.longest_run)
            flag("longest_free_run_bytes", 64'(want.longest_run), 64'(got.longest_run));
          if (got.done !== want.done)
            flag("scan_done", 64'(want.done), 64'(got.done));
          if (want.erase_valid) commands_seen++;
          if (want.done) scans_seen++;
        end
        results_seen++;
      end

      if (in_ch.valid && in_ch.ready) begin
        expected_q.push_back(scan_entry(in_ch.fat_entry, in_ch.last_entry));
      end
    end
    pending_results <= expected_q.size();
  end

endmodule

### bench/testbench.sv
`timescale 1ns / 1ps

module testbench;

  localparam int RANDOM_ITEMS     = 1750;
  localparam int STALL_LIMIT      = 4000;
  localparam int SINK_HOLD_CYCLES = 150;

  logic clk;
  logic rst_n;

  ffrs_in_if  in_if();
  ffrs_out_if out_if();
  ffrs_cfg_if cfg_if();

  int fail_count;
  int pending_results;
  int commands_seen;
  int scans_seen;

  int items_sent = 0;
  int settings_used = 0;
  int src_idle_pct = 0;
  int sink_idle_pct = 0;
  int idle_cycles = 0;
  bit hold_req = 1'b0;

  fat_free_run_erase_scanner dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_if),
    .out_if (out_if),
    .cfg_if (cfg_if)
  );

  erase_scan_checker erase_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_ch           (in_if),
    .out_ch          (out_if),
    .cfg_ch          (cfg_if),
    .fail_count      (fail_count),
    .pending_results (pending_results),
    .commands_seen   (commands_seen),
    .scans_seen      (scans_seen)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // result side: random backpressure plus an occasional long hold
  initial begin
    int hold_left;
    hold_left = 0;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_left = SINK_HOLD_CYCLES;
        hold_req  = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= ($urandom_range(99) >= sink_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("stalled with %0d results outstanding", pending_results);
      $display("testbench failed");
      $finish;
    end
  end

  function automatic logic [31:0] free_entry();
    return {4'($urandom_range(15)), 28'd0};
  endfunction

  function automatic logic [31:0] busy_entry();
    logic [31:0] e;
    do e = $urandom; while (e[27:0] == 28'd0);
    return e;
  endfunction

  task automatic send_entry(input logic [31:0] entry, input logic last);
    while ($urandom_range(99) < src_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid      <= 1'b1;
    in_if.fat_entry  <= entry;
    in_if.last_entry <= last;
    do @(posedge clk); while (!in_if.ready);
    items_sent++;
  endtask

  task automatic drain_results();
    in_if.valid <= 1'b0;
    do @(posedge clk); while (pending_results != 0);
  endtask

  task automatic set_geometry(input logic [31:0] start, input logic [7:0] spc);
    cfg_if.valid <= 1'b1;
    cfg_if.addr  <= ffrs_pkg::REG_DATA_START;
    cfg_if.data  <= start;
    do @(posedge clk); while (!cfg_if.ready);
    cfg_if.addr  <= ffrs_pkg::REG_SPC;
    cfg_if.data  <= {24'd0, spc};
    do @(posedge clk); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    settings_used++;
  endtask

  task automatic send_scan(input int length, input bit structured);
    int  i;
    int  run_left;
    bit  is_free;
    logic [31:0] e;
    is_free  = $urandom_range(1);
    run_left = $urandom_range(1, 12);
    for (i = 0; i < length; i++) begin
      if (structured) begin
        if (run_left == 0) begin
          is_free  = !is_free;
          run_left = is_free ? $urandom_range(1, 12) : $urandom_range(1, 4);
        end
        run_left--;
        e = is_free ? free_entry() : busy_entry();
      end else begin
        e = ($urandom_range(7) == 0) ? free_entry() : $urandom;
      end
      send_entry(e, i == length - 1);
    end
  endtask

  initial begin
    int   target;
    int   spc;
    int   group_no;
    logic [31:0] start;

    rst_n            <= 1'b0;
    in_if.valid      <= 1'b0;
    in_if.fat_entry  <= '0;
    in_if.last_entry <= 1'b0;
    cfg_if.valid     <= 1'b0;
    cfg_if.addr      <= '0;
    cfg_if.data      <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // geometry from reset, masked upper bits, runs ending on allocated and last
    send_entry(32'h0000_0000, 1'b0);
    send_entry(32'hF000_0000, 1'b0);
    send_entry(32'h0FFF_FFFF, 1'b0);
    send_entry(32'h0000_0001, 1'b0);
    send_entry(32'h0000_0000, 1'b0);
    send_entry(32'hFFFF_FFFF, 1'b0);
    send_entry(32'h1000_0000, 1'b1);
    drain_results();

    // start sector wrapping past 2^32
    set_geometry(32'hFFFF_FF00, 8'd255);
    send_entry(32'h0FFF_FFF8, 1'b0);
    send_entry(32'h0000_0000, 1'b0);
    send_entry(32'h0000_0000, 1'b0);
    send_entry(32'h0000_0002, 1'b0);
    send_entry(32'h0000_0000, 1'b1);
    drain_results();

    // zero cluster size
    set_geometry(32'h1234_5678, 8'd0);
    send_entry(32'h0000_0000, 1'b0);
    send_entry(32'h0000_0000, 1'b0);
    send_entry(32'h0000_0003, 1'b0);
    send_entry(32'h0000_0000, 1'b1);
    drain_results();

    set_geometry(32'hFFFF_FFFF, 8'd1);
    send_entry(32'h0FFF_FFF7, 1'b1);
    send_entry(32'h0000_0000, 1'b1);
    drain_results();

    set_geometry(32'h0000_0000, 8'd128);
    send_entry(32'h0000_0000, 1'b0);
    send_entry(32'h0000_0000, 1'b0);
    send_entry(32'h0000_0000, 1'b1);
    drain_results();

    group_no = 0;
    target   = items_sent + RANDOM_ITEMS;
    while (items_sent < target) begin
      drain_results();
      start = ($urandom_range(3) == 0) ? (32'hFFFF_F000 | $urandom_range(4095)) : $urandom;
      if ($urandom_range(3) == 0) spc = $urandom_range(255);
      else spc = 1 << $urandom_range(7);
      set_geometry(start, 8'(spc));
      src_idle_pct  = ($urandom_range(3) == 0) ? 0 : 35;
      sink_idle_pct = ($urandom_range(3) == 0) ? 0 : 35;
      if (group_no == 1) begin
        // sustained stretch with both sides always ready
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        repeat (6) send_scan(40, 1'b1);
      end else begin
        if (group_no == 0 || $urandom_range(9) == 0) hold_req = 1'b1;
        repeat ($urandom_range(1, 4)) send_scan($urandom_range(1, 40), $urandom_range(9) < 8);
      end
      group_no++;
    end

    drain_results();
    repeat (8) @(posedge clk);
    $display("sent %0d fat entries in %0d scans across %0d geometry settings",
             items_sent, scans_seen, settings_used);
    $display("checked %0d erase commands, including wrapped start sectors and empty clusters",
             commands_seen);
    if (fail_count == 0 && pending_results == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule
